// File: rtl/qenc_pkg.sv
`default_nettype none

package qenc_pkg;

   localparam int COUNT_W   = 16;
   localparam int DIV_W     = 10;
   localparam int FREQ_W    = 32;
   localparam int DIV_STEPS = COUNT_W;
   localparam int ITER_W    = $clog2(DIV_STEPS);
   localparam int MAG_W     = DIV_W + 16;

   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [15:0] FEC_MAX = 16'hFFFF;

   // Register map, word index into the configuration space
   typedef enum logic [2:0] {
      REG_FAST_INTERVAL = 3'd0,
      REG_FAST_TRIGGER  = 3'd1,
      REG_IDLE_TIMEOUT  = 3'd2,
      REG_FAST_MULT     = 3'd3,
      REG_FREQ_STEP     = 3'd4,
      REG_MENU_DIV      = 3'd5,
      REG_VALUE_DIV     = 3'd6,
      REG_REVERSE       = 3'd7
   } reg_index_type;

   localparam logic [31:0] RST_FAST_INTERVAL = 32'd1000;
   localparam logic [15:0] RST_FAST_TRIGGER  = 16'd50;
   localparam logic [31:0] RST_IDLE_TIMEOUT  = 32'd38333;
   localparam logic [9:0]  RST_FAST_MULT     = 10'd100;
   localparam logic [15:0] RST_FREQ_STEP     = 16'd1;
   localparam logic [9:0]  RST_MENU_DIV      = 10'd10;
   localparam logic [9:0]  RST_VALUE_DIV     = 10'd1;

   typedef struct packed {
      logic load;
      logic step;
      logic speed;
      logic iter;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/qenc_ctrl.sv
`default_nettype none

module qenc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  qenc_pkg::status_type status,
   output qenc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SPEED,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd        = '0;
      cmd.load   = req_valid && !req_stall_ff;
      cmd.step   = (state_ff == ST_STEP);
      cmd.speed  = (state_ff == ST_SPEED);
      cmd.iter   = (state_ff == ST_DIV);
      cmd.finish = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_STEP;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_STEP: begin
               state_ff <= ST_SPEED;
            end
            ST_SPEED: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  req_stall_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over an untaken result");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall_ff) |=> (state_ff == ST_STEP))
      else $error("accepted transaction did not start processing");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall_ff |-> (state_ff == ST_IDLE))
      else $error("input open while busy");

endmodule

`default_nettype wire

// File: rtl/qenc_dpath.sv
`default_nettype none

module qenc_dpath #(
   parameter int TIME_WIDTH = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  qenc_pkg::cmd_type       cmd,
   output qenc_pkg::status_type    status,
   input  wire [31:0]              fast_interval_ticks,
   input  wire [15:0]              fast_trigger_count,
   input  wire [31:0]              idle_timeout_ticks,
   input  wire [9:0]               fast_multiplier,
   input  wire [15:0]              freq_step_size,
   input  wire [9:0]               menu_divisor,
   input  wire [9:0]               value_divisor,
   input  wire                     reverse_direction,
   input  wire                     in_edge_channel,
   input  wire                     in_pin_q,
   input  wire                     in_pin_i,
   input  wire [TIME_WIDTH-1:0]    in_timestamp,
   input  wire                     in_menu_taken,
   input  wire                     in_value_taken,
   output logic signed [31:0]      out_freq_step,
   output logic signed [7:0]       out_menu_steps,
   output logic signed [15:0]      out_value_steps,
   output logic                    out_menu_new,
   output logic                    out_value_new,
   output logic                    out_fast_active
);

   localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   // latched transaction
   logic                  chan_ff, pin_q_ff, pin_i_ff, menu_tk_ff, value_tk_ff;
   logic [TIME_WIDTH-1:0] now_ff;

   // persistent state
   logic [15:0]           count_ff;
   logic                  menu_flag_ff, menu_seen_ff, value_flag_ff, value_seen_ff;
   logic                  fast_mode_ff, dir_chg_ff;
   logic [15:0]           fec_ff;
   logic [TIME_WIDTH-1:0] last_time_ff;
   logic [1:0]            last_dir_ff;

   // per-transaction working registers
   logic                  up_ff, fwd_ff, back_ff, idle_ff, quick_ff;
   logic [9:0]            dm_ff, dv_ff, rm_ff, rv_ff;
   logic [15:0]           qm_ff, qv_ff;
   logic [qenc_pkg::ITER_W-1:0] iter_ff;
   logic [qenc_pkg::MAG_W-1:0]  mag_ff;

   // step stage
   logic                  menu_flag_c, value_flag_c, clear_m, clear_v, up_c, fwd_c;
   logic [15:0]           base_c, count_c;
   logic [TIME_WIDTH-1:0] delta_c;

   always_comb begin
      menu_flag_c  = menu_flag_ff & ~menu_tk_ff;
      value_flag_c = value_flag_ff & ~value_tk_ff;
      up_c         = pin_q_ff ^ pin_i_ff ^ ~chan_ff;
      fwd_c        = up_c ^ reverse_direction;
      clear_m      = menu_seen_ff & ~menu_flag_c;
      clear_v      = ~clear_m & value_seen_ff & ~value_flag_c;
      base_c       = (clear_m || clear_v) ? 16'd0 : count_ff;
      count_c      = fwd_c ? base_c + 16'd1 : base_c - 16'd1;
      delta_c      = now_ff - last_time_ff;
   end

   // speed stage
   logic [15:0] fec_c;
   logic        fm_c, dc_c;
   logic [1:0]  dir_c;

   always_comb begin
      fec_c = fec_ff;
      fm_c  = fast_mode_ff;
      if (!back_ff) begin
         if (idle_ff) begin
            fm_c  = 1'b0;
            fec_c = 16'd0;
         end else if (quick_ff && fec_ff != qenc_pkg::FEC_MAX) begin
            fec_c = fec_ff + 16'd1;
         end
      end
      if (fec_c > fast_trigger_count) begin
         fm_c = 1'b1;
      end
      dir_c = up_ff ? qenc_pkg::DIR_UP : qenc_pkg::DIR_DOWN;
      dc_c  = dir_chg_ff;
      if (last_dir_ff != dir_c) begin
         dc_c = ~dir_chg_ff;
      end else if (dir_chg_ff) begin
         // direction change confirmed: drop fast mode
         fm_c  = 1'b0;
         dc_c  = 1'b0;
         fec_c = 16'd0;
      end
   end

   // divider step, two lanes in lockstep
   logic [10:0] rm_sh, rv_sh;
   logic        qm_bit, qv_bit;
   logic [15:0] abs_c;

   always_comb begin
      abs_c  = count_ff[15] ? 16'(-count_ff) : count_ff;
      rm_sh  = {rm_ff, qm_ff[15]};
      rv_sh  = {rv_ff, qv_ff[15]};
      qm_bit = (rm_sh >= {1'b0, dm_ff});
      qv_bit = (rv_sh >= {1'b0, dv_ff});
   end

   // finish stage
   logic [15:0] mq_c, vq_c;
   logic        mset_c, vset_c;

   always_comb begin
      mq_c   = count_ff[15] ? 16'(-qm_ff) : qm_ff;
      vq_c   = count_ff[15] ? 16'(-qv_ff) : qv_ff;
      mset_c = (mq_c[7:0] != 8'd0);
      vset_c = (vq_c != 16'd0);
   end

   assign status.div_last = (iter_ff == qenc_pkg::ITER_W'(qenc_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         menu_flag_ff  <= 1'b0;
         menu_seen_ff  <= 1'b0;
         value_flag_ff <= 1'b0;
         value_seen_ff <= 1'b0;
         fast_mode_ff  <= 1'b0;
         dir_chg_ff    <= 1'b0;
         fec_ff        <= '0;
         last_time_ff  <= '0;
         last_dir_ff   <= '0;
      end else begin
         if (cmd.step) begin
            count_ff      <= count_c;
            menu_flag_ff  <= menu_flag_c;
            value_flag_ff <= value_flag_c;
            menu_seen_ff  <= menu_seen_ff & ~clear_m;
            value_seen_ff <= value_seen_ff & ~clear_v;
            last_time_ff  <= now_ff;
         end
         if (cmd.speed) begin
            fec_ff       <= fec_c;
            fast_mode_ff <= fm_c;
            dir_chg_ff   <= dc_c;
            last_dir_ff  <= dir_c;
         end
         if (cmd.finish) begin
            if (mset_c) begin
               menu_flag_ff <= 1'b1;
               menu_seen_ff <= 1'b1;
            end
            if (vset_c) begin
               value_flag_ff <= 1'b1;
               value_seen_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_ff     <= in_edge_channel;
         pin_q_ff    <= in_pin_q;
         pin_i_ff    <= in_pin_i;
         now_ff      <= in_timestamp;
         menu_tk_ff  <= in_menu_taken;
         value_tk_ff <= in_value_taken;
      end
      if (cmd.step) begin
         up_ff    <= up_c;
         fwd_ff   <= fwd_c;
         back_ff  <= (last_time_ff > now_ff);
         idle_ff  <= (CMP_W'(delta_c) > CMP_W'(idle_timeout_ticks));
         quick_ff <= (CMP_W'(fast_interval_ticks) >= CMP_W'(delta_c));
      end
      if (cmd.speed) begin
         qm_ff   <= abs_c;
         qv_ff   <= abs_c;
         rm_ff   <= '0;
         rv_ff   <= '0;
         iter_ff <= '0;
         dm_ff   <= (menu_divisor == 10'd0) ? 10'd1 : menu_divisor;
         dv_ff   <= (value_divisor == 10'd0) ? 10'd1 : value_divisor;
      end
      if (cmd.iter) begin
         rm_ff   <= qm_bit ? 10'(rm_sh - {1'b0, dm_ff}) : rm_sh[9:0];
         rv_ff   <= qv_bit ? 10'(rv_sh - {1'b0, dv_ff}) : rv_sh[9:0];
         qm_ff   <= {qm_ff[14:0], qm_bit};
         qv_ff   <= {qv_ff[14:0], qv_bit};
         iter_ff <= iter_ff + qenc_pkg::ITER_W'(1);
         mag_ff  <= (fast_mode_ff ? fast_multiplier : 10'd1) * freq_step_size;
      end
      if (cmd.finish) begin
         out_freq_step   <= fwd_ff ? 32'(mag_ff) : -32'(mag_ff);
         out_menu_steps  <= mq_c[7:0];
         out_value_steps <= vq_c;
         out_menu_new    <= menu_flag_ff | mset_c;
         out_value_new   <= value_flag_ff | vset_c;
         out_fast_active <= fast_mode_ff;
      end
   end

   a_count_moves_one: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (count_ff == $past(count_ff) + 16'd1 ||
                    count_ff == $past(count_ff) - 16'd1 ||
                    count_ff == 16'd1 || count_ff == 16'hFFFF))
      else $error("step count moved by more than one edge");

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.iter |-> (rm_ff < dm_ff && rv_ff < dv_ff))
      else $error("divider remainder out of range");

endmodule

`default_nettype wire

// File: rtl/quadrature_encoder_dual_speed.sv
// Quadrature encoder with dual-speed acceleration. Each input transaction is
// one encoder edge (edged channel, both pin levels, timestamp, consumer
// acknowledgements) and yields exactly one result transaction: the signed
// frequency delta, the menu and value quotients of the accumulated step
// count, the pending-result flags and the fast-mode indication. A new edge
// is not accepted while a transaction is in progress; the next one is
// accepted in the cycle after the result is loaded. Each transaction runs
// the count update, the speed update, the two-lane restoring divider,
// which produces both quotients side by side at one bit per cycle, and
// the result load, which waits until the output register is free. A
// finished result sits in the output register while the next edge is
// accepted. Configuration registers sit at byte address 4*i and must be
// written only while the block is idle; the block does not enforce this.

`default_nettype none

module quadrature_encoder_dual_speed #(
   parameter int TIME_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   // edge input channel
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_edge_channel,
   input  wire                   req_pin_q,
   input  wire                   req_pin_i,
   input  wire [TIME_WIDTH-1:0]  req_timestamp,
   input  wire                   req_menu_taken,
   input  wire                   req_value_taken,
   // result channel
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic signed [31:0]    rsp_freq_step,
   output logic signed [7:0]     rsp_menu_steps,
   output logic signed [15:0]    rsp_value_steps,
   output logic                  rsp_menu_new,
   output logic                  rsp_value_new,
   output logic                  rsp_fast_active,
   // configuration port
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire [4:0]             paddr,
   input  wire [31:0]            pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Configuration registers
   logic [31:0] fast_interval_ff;
   logic [15:0] fast_trigger_ff;
   logic [31:0] idle_timeout_ff;
   logic [9:0]  fast_mult_ff;
   logic [15:0] freq_step_ff;
   logic [9:0]  menu_div_ff;
   logic [9:0]  value_div_ff;
   logic        reverse_ff;

   logic                    csr_write;
   qenc_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   // word index; byte-lane bits of the address are ignored
   assign csr_index = qenc_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_interval_ff <= qenc_pkg::RST_FAST_INTERVAL;
         fast_trigger_ff  <= qenc_pkg::RST_FAST_TRIGGER;
         idle_timeout_ff  <= qenc_pkg::RST_IDLE_TIMEOUT;
         fast_mult_ff     <= qenc_pkg::RST_FAST_MULT;
         freq_step_ff     <= qenc_pkg::RST_FREQ_STEP;
         menu_div_ff      <= qenc_pkg::RST_MENU_DIV;
         value_div_ff     <= qenc_pkg::RST_VALUE_DIV;
         reverse_ff       <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            qenc_pkg::REG_FAST_INTERVAL: fast_interval_ff <= pwdata;
            qenc_pkg::REG_FAST_TRIGGER:  fast_trigger_ff  <= pwdata[15:0];
            qenc_pkg::REG_IDLE_TIMEOUT:  idle_timeout_ff  <= pwdata;
            qenc_pkg::REG_FAST_MULT:     fast_mult_ff     <= pwdata[9:0];
            qenc_pkg::REG_FREQ_STEP:     freq_step_ff     <= pwdata[15:0];
            qenc_pkg::REG_MENU_DIV:      menu_div_ff      <= pwdata[9:0];
            qenc_pkg::REG_VALUE_DIV:     value_div_ff     <= pwdata[9:0];
            qenc_pkg::REG_REVERSE:       reverse_ff       <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Read back: zero-extend each register to the bus width
   always_comb begin
      case (csr_index)
         qenc_pkg::REG_FAST_INTERVAL: prdata = fast_interval_ff;
         qenc_pkg::REG_FAST_TRIGGER:  prdata = 32'(fast_trigger_ff);
         qenc_pkg::REG_IDLE_TIMEOUT:  prdata = idle_timeout_ff;
         qenc_pkg::REG_FAST_MULT:     prdata = 32'(fast_mult_ff);
         qenc_pkg::REG_FREQ_STEP:     prdata = 32'(freq_step_ff);
         qenc_pkg::REG_MENU_DIV:      prdata = 32'(menu_div_ff);
         qenc_pkg::REG_VALUE_DIV:     prdata = 32'(value_div_ff);
         qenc_pkg::REG_REVERSE:       prdata = 32'(reverse_ff);
         default:                     prdata = '0;
      endcase
   end

   // Controller sequences each transaction: latch, count update, speed
   // update and divider setup, 16 divider steps, then result load once the
   // output register is free.
   qenc_pkg::cmd_type    cmd;
   qenc_pkg::status_type status;

   qenc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath holds the step count, flags, speed detector state, the
   // two-lane divider and the output payload registers.
   qenc_dpath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .fast_interval_ticks (fast_interval_ff),
      .fast_trigger_count  (fast_trigger_ff),
      .idle_timeout_ticks  (idle_timeout_ff),
      .fast_multiplier     (fast_mult_ff),
      .freq_step_size      (freq_step_ff),
      .menu_divisor        (menu_div_ff),
      .value_divisor       (value_div_ff),
      .reverse_direction   (reverse_ff),
      .in_edge_channel     (req_edge_channel),
      .in_pin_q            (req_pin_q),
      .in_pin_i            (req_pin_i),
      .in_timestamp        (req_timestamp),
      .in_menu_taken       (req_menu_taken),
      .in_value_taken      (req_value_taken),
      .out_freq_step       (rsp_freq_step),
      .out_menu_steps      (rsp_menu_steps),
      .out_value_steps     (rsp_value_steps),
      .out_menu_new        (rsp_menu_new),
      .out_value_new       (rsp_value_new),
      .out_fast_active     (rsp_fast_active)
   );

endmodule

`default_nettype wire
